>>> rtl/core/rfsa_pkg.sv
// ----------------------------------------------------------------------------
// rfsa_pkg
// Shared types and constants of the rotating free-server allocator.
// ----------------------------------------------------------------------------
package rfsa_pkg;

  // Built server count used as the default of the top-level parameter.
  localparam int unsigned SERVERS_DEF = 16;

  // Largest number of results that one report produces.
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned RES_CNT_W   = $clog2(MAX_RESULTS + 1);

  // Field widths.
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned TIME_W      = 31;
  localparam int unsigned TOTAL_W     = 32;
  localparam int unsigned IDX_OUT_W   = 4;
  localparam int unsigned IN_DATA_W   = 64;
  localparam int unsigned OUT_DATA_W  = 40;

  // Reset value of the server count register.
  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // Command codes carried in the input tuser.
  localparam logic CMD_REQUEST = 1'b0;
  localparam logic CMD_REPORT  = 1'b1;

  // One stored server entry.
  typedef struct packed {
    logic [TOTAL_W-1:0] busy;
    logic [TOTAL_W-1:0] total;
  } entry_t;

  // Sequencer states, one-hot.
  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_NORM  = 6'b000010,
    ST_RD    = 6'b000100,
    ST_EVAL  = 6'b001000,
    ST_GRANT = 6'b010000,
    ST_DROP  = 6'b100000
  } state_e;

endpackage

>>> rtl/core/rotating_free_server_allocator_core.sv
// ----------------------------------------------------------------------------
// rotating_free_server_allocator_core
// Assigns timed jobs to the first free server in rotating order and reports
// the busiest servers on request.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on the s_axis channel: tuser selects a job request or a report,
// tdata carries the arrival time and the load duration. Results leave on the
// m_axis channel with tlast on the final result of each item. The server
// count is to be written on the cfg channel only while the block is idle;
// the block itself does not enforce this. Server state lives in one memory
// of SERVERS entries, read one entry at a time: each entry is read (RD) and
// then evaluated (EVAL). A request scans from the start pointer until it
// finds a free server, or is dropped once it has seen every active one; after
// a shrunk server count the start pointer is first brought below the count
// by repeated subtraction. A report scans twice, and output stalls hold it.
// Input is taken in the idle state, also while the last result still waits
// in the output register.
// At reset every entry reads as zero through per-entry valid bits, so no
// clearing pass is needed. When the receiver stalls, the result is held in
// the output register and the sequencer waits before emitting the next.
// ----------------------------------------------------------------------------
module rotating_free_server_allocator_core #(
  parameter int unsigned SERVERS = rfsa_pkg::SERVERS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration: server count.
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [rfsa_pkg::CFG_W-1:0]       cfg_data_i,
  // Input items.
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rfsa_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,  // arrival_time, load_duration
  input  logic                             s_axis_tuser_i,  // command
  // Result items.
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [rfsa_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,  // server_index, served_total
  output logic                             m_axis_tuser_o,  // accepted
  output logic                             m_axis_tlast_o
);

  localparam int unsigned IDXW = (SERVERS > 1) ? $clog2(SERVERS) : 1;
  localparam int unsigned CNTW = $clog2(SERVERS + 1);
  localparam int unsigned EW   = $bits(rfsa_pkg::entry_t);
  localparam int unsigned TW   = rfsa_pkg::TOTAL_W;

  rfsa_pkg::state_e state_q, state_d;

  logic                          cmd_q, cmd_d;
  logic [rfsa_pkg::TIME_W-1:0]   time_q, time_d;
  logic [rfsa_pkg::TIME_W-1:0]   load_q, load_d;
  logic [IDXW-1:0]               ptr_q, ptr_d;
  logic [IDXW-1:0]               idx_q, idx_d;
  logic [IDXW-1:0]               k_q, k_d;
  logic                          pass_q, pass_d;
  logic [TW-1:0]                 top_q, top_d;
  logic [CNTW-1:0]               match_q, match_d;
  logic [rfsa_pkg::RES_CNT_W-1:0] sent_q, sent_d;
  logic [TW-1:0]                 total_q, total_d;
  logic [SERVERS-1:0]            valid_q, valid_d;
  logic [rfsa_pkg::CFG_W-1:0]    cfg_q, cfg_d;

  logic                          out_valid_q, out_valid_d;
  logic                          out_acc_q, out_acc_d;
  logic [IDXW-1:0]               out_idx_q, out_idx_d;
  logic [TW-1:0]                 out_total_q, out_total_d;
  logic                          out_last_q, out_last_d;

  logic                          ram_we, ram_re;
  logic [EW-1:0]                 ram_wdata, ram_rdata;
  rfsa_pkg::entry_t              ent, wr_ent;

  logic [31:0]                   act_full;
  logic [CNTW-1:0]               cnt;
  logic                          out_free;
  logic                          last_k, last_idx, last_ptr;
  logic [IDXW-1:0]               idx_next, ptr_next;
  logic [TW-1:0]                 total_inc;
  logic [rfsa_pkg::RES_CNT_W-1:0] lim;
  logic                          s_xfer;

  // Active server count: zero counts as one, large values are limited.
  always_comb begin
    act_full = 32'(cfg_q);
    if (act_full == 32'd0) begin
      act_full = 32'd1;
    end else if (act_full > 32'(SERVERS)) begin
      act_full = 32'(SERVERS);
    end
  end
  assign cnt = CNTW'(act_full);

  // Helpers for wrapping the search index and the start pointer.
  assign last_k   = (32'(k_q) == 32'(cnt) - 32'd1);
  assign last_idx = (32'(idx_q) == 32'(cnt) - 32'd1);
  assign last_ptr = (32'(ptr_q) == 32'(cnt) - 32'd1);
  assign idx_next = last_idx ? '0 : idx_q + 1'b1;
  assign ptr_next = last_ptr ? '0 : ptr_q + 1'b1;

  // Entry as seen by the logic: entries never written read as zero.
  assign ent       = valid_q[idx_q] ? rfsa_pkg::entry_t'(ram_rdata) : '0;
  assign total_inc = (ent.total == '1) ? ent.total : ent.total + 1'b1;

  // Number of results that the report will emit.
  assign lim = (32'(match_q) > 32'(rfsa_pkg::MAX_RESULTS)) ?
               rfsa_pkg::RES_CNT_W'(rfsa_pkg::MAX_RESULTS) :
               rfsa_pkg::RES_CNT_W'(match_q);

  assign out_free = !out_valid_q || m_axis_tready_i;
  assign s_xfer   = s_axis_tvalid_i && s_axis_tready_o;

  // Data written back for a granted request.
  always_comb begin
    wr_ent.busy  = {1'b0, time_q} + {1'b0, load_q};
    wr_ent.total = total_q;
  end
  assign ram_wdata = EW'(wr_ent);

  // Sequencer: search, write back and report scans.
  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    time_d      = time_q;
    load_d      = load_q;
    ptr_d       = ptr_q;
    idx_d       = idx_q;
    k_d         = k_q;
    pass_d      = pass_q;
    top_d       = top_q;
    match_d     = match_q;
    sent_d      = sent_q;
    total_d     = total_q;
    valid_d     = valid_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_acc_d   = out_acc_q;
    out_idx_d   = out_idx_q;
    out_total_d = out_total_q;
    out_last_d  = out_last_q;

    case (state_q)
      rfsa_pkg::ST_IDLE: begin
        if (s_xfer) begin
          cmd_d   = s_axis_tuser_i;
          time_d  = s_axis_tdata_i[rfsa_pkg::TIME_W-1:0];
          load_d  = s_axis_tdata_i[2*rfsa_pkg::TIME_W-1:rfsa_pkg::TIME_W];
          state_d = rfsa_pkg::ST_NORM;
        end
      end

      // A request first brings the start pointer below the active count; a
      // report leaves the pointer as it is. Then a scan starts.
      rfsa_pkg::ST_NORM: begin
        if ((cmd_q == rfsa_pkg::CMD_REQUEST) && (32'(ptr_q) >= 32'(cnt))) begin
          ptr_d = IDXW'(32'(ptr_q) - 32'(cnt));
        end else begin
          idx_d   = (cmd_q == rfsa_pkg::CMD_REPORT) ? '0 : ptr_q;
          k_d     = '0;
          pass_d  = 1'b0;
          top_d   = '0;
          match_d = '0;
          sent_d  = '0;
          state_d = rfsa_pkg::ST_RD;
        end
      end

      rfsa_pkg::ST_RD: begin
        ram_re  = 1'b1;
        state_d = rfsa_pkg::ST_EVAL;
      end

      rfsa_pkg::ST_EVAL: begin
        if (cmd_q == rfsa_pkg::CMD_REQUEST) begin
          // First free server in rotating order.
          if (ent.busy <= {1'b0, time_q}) begin
            total_d = total_inc;
            state_d = rfsa_pkg::ST_GRANT;
          end else if (last_k) begin
            state_d = rfsa_pkg::ST_DROP;
          end else begin
            idx_d   = idx_next;
            k_d     = k_q + 1'b1;
            state_d = rfsa_pkg::ST_RD;
          end
        end else if (!pass_q) begin
          // First report pass: highest count and how many servers hold it.
          if (ent.total > top_q) begin
            top_d   = ent.total;
            match_d = CNTW'(1);
          end else if (ent.total == top_q) begin
            match_d = match_q + 1'b1;
          end
          if (last_k) begin
            pass_d = 1'b1;
            idx_d  = '0;
            k_d    = '0;
          end else begin
            idx_d = idx_next;
            k_d   = k_q + 1'b1;
          end
          state_d = rfsa_pkg::ST_RD;
        end else begin
          // Second report pass: emit every server holding the highest count, up to MAX_RESULTS.
          if (ent.total == top_q) begin
            if (out_free) begin
              out_valid_d = 1'b1;
              out_acc_d   = 1'b1;
              out_idx_d   = idx_q;
              out_total_d = ent.total;
              out_last_d  = (sent_q + 1'b1 == lim);
              sent_d      = sent_q + 1'b1;
              if ((sent_q + 1'b1 == lim) || last_k) begin
                state_d = rfsa_pkg::ST_IDLE;
              end else begin
                idx_d   = idx_next;
                k_d     = k_q + 1'b1;
                state_d = rfsa_pkg::ST_RD;
              end
            end
          end else if (last_k) begin
            state_d = rfsa_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_next;
            k_d     = k_q + 1'b1;
            state_d = rfsa_pkg::ST_RD;
          end
        end
      end

      rfsa_pkg::ST_GRANT: begin
        if (out_free) begin
          ram_we         = 1'b1;
          valid_d[idx_q] = 1'b1;
          out_valid_d    = 1'b1;
          out_acc_d      = 1'b1;
          out_idx_d      = idx_q;
          out_total_d    = total_q;
          out_last_d     = 1'b1;
          ptr_d          = ptr_next;
          state_d        = rfsa_pkg::ST_IDLE;
        end
      end

      rfsa_pkg::ST_DROP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_acc_d   = 1'b0;
          out_idx_d   = '0;
          out_total_d = '0;
          out_last_d  = 1'b1;
          ptr_d       = ptr_next;
          state_d     = rfsa_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = rfsa_pkg::ST_IDLE;
      end
    endcase
  end

  // Server count register.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      cfg_d = cfg_data_i;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rfsa_pkg::ST_IDLE;
      ptr_q       <= '0;
      valid_q     <= '0;
      cfg_q       <= rfsa_pkg::CFG_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      valid_q     <= valid_d;
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    time_q      <= time_d;
    load_q      <= load_d;
    idx_q       <= idx_d;
    k_q         <= k_d;
    pass_q      <= pass_d;
    top_q       <= top_d;
    match_q     <= match_d;
    sent_q      <= sent_d;
    total_q     <= total_d;
    out_acc_q   <= out_acc_d;
    out_idx_q   <= out_idx_d;
    out_total_q <= out_total_d;
    out_last_q  <= out_last_d;
  end

  // Server state memory: busy-until time and served count per entry.
  rfsa_ram #(
    .WIDTH (EW),
    .DEPTH (SERVERS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  // Ports.
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == rfsa_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_acc_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {{(rfsa_pkg::OUT_DATA_W - TW - rfsa_pkg::IDX_OUT_W){1'b0}},
                            out_total_q, rfsa_pkg::IDX_OUT_W'(out_idx_q)};

endmodule

>>> rtl/core/rfsa_ram.sv
// ----------------------------------------------------------------------------
// rfsa_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rfsa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the rotating free-server allocator. A directed plan
// covers reset state, drops, the server count limits and a shrinking start
// pointer. Several random phases at different server counts follow, with
// random gaps, stalls and back-pressure. Every result transfer is checked
// against a cycle-free predictor of the server bank.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned HALF_PERIOD  = 4;
  localparam int unsigned SETTLE       = 100;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam logic [rfsa_pkg::TIME_W-1:0] TIME_MAX = {rfsa_pkg::TIME_W{1'b1}};

  // One result as it leaves the block.
  typedef struct packed {
    logic                           accepted;
    logic [rfsa_pkg::IDX_OUT_W-1:0] index;
    logic [rfsa_pkg::TOTAL_W-1:0]   total;
    logic                           last;
  } result_t;

  // One line of the directed plan: either a server count write or an item.
  typedef enum logic {ROW_SETUP, ROW_JOB} row_kind_e;
  typedef struct packed {
    row_kind_e                     kind;
    logic [rfsa_pkg::CFG_W-1:0]    setting;
    logic                          cmd;
    logic [rfsa_pkg::TIME_W-1:0]   arrival;
    logic [rfsa_pkg::TIME_W-1:0]   load;
    logic                          typed;
    result_t                       want;
  } plan_row_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_valid;
  logic                            cfg_ready_o;
  logic [rfsa_pkg::CFG_W-1:0]      cfg_data;
  logic                            item_valid;
  logic                            s_axis_tready_o;
  logic [rfsa_pkg::IN_DATA_W-1:0]  item_data;
  logic                            item_user;
  logic                            m_axis_tvalid_o;
  logic                            result_ready;
  logic [rfsa_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tuser_o;
  logic                            m_axis_tlast_o;

  // Predictor state: the server bank and the search pointer.
  logic [rfsa_pkg::TOTAL_W-1:0]    busy_until_q [rfsa_pkg::SERVERS_DEF];
  logic [rfsa_pkg::TOTAL_W-1:0]    served_q [rfsa_pkg::SERVERS_DEF];
  int unsigned                     rotate_ptr;
  logic [rfsa_pkg::CFG_W-1:0]      server_limit;

  result_t                         expected_results [$];
  plan_row_t                       directed_plan [$];
  int unsigned                     mismatch_count;
  int unsigned                     quiet_cycles;
  logic                            steady_source;
  int unsigned                     hold_requests;
  logic [rfsa_pkg::TIME_W-1:0]     clock_base;

  rotating_free_server_allocator_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (item_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (item_data),    // arrival_time, load_duration
    .s_axis_tuser_i  (item_user),    // command
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (result_ready),
    .m_axis_tdata_o  (m_axis_tdata_o), // server_index, served_total
    .m_axis_tuser_o  (m_axis_tuser_o), // accepted
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Number of servers actually searched for the current register value.
  function automatic int unsigned active_servers();
    if (server_limit == '0) return 1;
    if (server_limit > rfsa_pkg::SERVERS_DEF) return rfsa_pkg::SERVERS_DEF;
    return 32'(server_limit);
  endfunction

  // Appends one expected result at the tail of the scoreboard.
  task automatic queue_result(input result_t res);
    expected_results.insert(expected_results.size(), res);
  endtask

  // Applies one accepted item to the predicted bank and queues its results.
  task automatic predict_allocation(input logic cmd,
                                    input logic [rfsa_pkg::TIME_W-1:0] arrival,
                                    input logic [rfsa_pkg::TIME_W-1:0] load);
    int unsigned   n;
    int unsigned   start;
    int unsigned   idx;
    int unsigned   pick;
    int            final_match;
    logic          found;
    logic [rfsa_pkg::TOTAL_W-1:0] top;
    result_t       res;
    n = active_servers();
    if (cmd == rfsa_pkg::CMD_REQUEST) begin
      start = rotate_ptr % n;
      found = 1'b0;
      pick  = 0;
      for (int k = 0; k < n; k++) begin
        idx = (start + k) % n;
        if (!found && busy_until_q[idx] <= {1'b0, arrival}) begin
          pick  = idx;
          found = 1'b1;
        end
      end
      rotate_ptr = (start + 1) % n;
      if (!found) begin
        res = '{accepted: 1'b0, index: '0, total: '0, last: 1'b1};
      end else begin
        busy_until_q[pick] = {1'b0, arrival} + {1'b0, load};
        if (served_q[pick] != '1) served_q[pick] = served_q[pick] + 1'b1;
        res = '{accepted: 1'b1, index: pick[rfsa_pkg::IDX_OUT_W-1:0],
                total: served_q[pick], last: 1'b1};
      end
      queue_result(res);
    end else begin
      // The report lists every active server that ties for the highest count.
      top = '0;
      for (int j = 0; j < n; j++) begin
        if (served_q[j] > top) top = served_q[j];
      end
      final_match = 0;
      for (int j = 0; j < n; j++) begin
        if (served_q[j] == top) final_match = j;
      end
      for (int j = 0; j < n; j++) begin
        if (served_q[j] == top) begin
          res = '{accepted: 1'b1, index: j[rfsa_pkg::IDX_OUT_W-1:0], total: served_q[j],
                  last: (j == final_match)};
          queue_result(res);
        end
      end
    end
  endtask

  // Lowers the item valid and waits until every expected result has arrived.
  task automatic wait_for_drain();
    @(negedge clk_i);
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Writes the server count once the block has gone idle.
  task automatic write_server_count(input logic [rfsa_pkg::CFG_W-1:0] value);
    wait_for_drain();
    repeat (SETTLE) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    server_limit = value;
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Offers one item after a random gap and predicts it on its transfer. A typed
  // row replaces the predicted single result by the one written in the plan.
  task automatic offer_item(input logic cmd, input logic [rfsa_pkg::TIME_W-1:0] arrival,
                            input logic [rfsa_pkg::TIME_W-1:0] load, input logic typed,
                            input result_t want);
    int unsigned gap;
    gap = steady_source ? 0 : $urandom_range(0, 15);
    @(negedge clk_i);
    if (gap != 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    item_valid <= 1'b1;
    item_user  <= cmd;
    item_data  <= {{(rfsa_pkg::IN_DATA_W - 2 * rfsa_pkg::TIME_W){1'b0}}, load, arrival};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predict_allocation(cmd, arrival, load);
    if (typed) begin
      void'(expected_results.pop_back());
      queue_result(want);
    end
  endtask

  task automatic plan_setup(input logic [rfsa_pkg::CFG_W-1:0] value);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_SETUP;
    row.setting = value;
    directed_plan.insert(directed_plan.size(), row);
  endtask

  task automatic plan_job(input logic cmd, input logic [rfsa_pkg::TIME_W-1:0] arrival,
                          input logic [rfsa_pkg::TIME_W-1:0] load, input logic typed,
                          input logic acc, input int unsigned idx,
                          input int unsigned total);
    plan_row_t row;
    row = '0;
    row.kind    = ROW_JOB;
    row.cmd     = cmd;
    row.arrival = arrival;
    row.load    = load;
    row.typed   = typed;
    row.want    = '{accepted: acc, index: idx[rfsa_pkg::IDX_OUT_W-1:0], total: total,
                    last: 1'b1};
    directed_plan.insert(directed_plan.size(), row);
  endtask

  // One random phase at a given server count. The squeeze option makes the
  // receiver hold off while items keep coming; the drain option pauses the
  // sender half way until the block is empty.
  task automatic run_phase(input logic [rfsa_pkg::CFG_W-1:0] setting,
                           input int unsigned items,
                           input logic top_range, input logic squeeze,
                           input logic drain_midway);
    logic                        cmd;
    logic [rfsa_pkg::TIME_W-1:0] arrival;
    logic [rfsa_pkg::TIME_W-1:0] load;
    write_server_count(setting);
    steady_source = squeeze || ($urandom_range(0, 3) == 0);
    if (squeeze) hold_requests++;
    if (top_range) clock_base = TIME_MAX - 31'd4000;
    for (int i = 0; i < items; i++) begin
      if (drain_midway && i == items / 2) wait_for_drain();
      cmd = ($urandom_range(0, 6) == 0) ? rfsa_pkg::CMD_REPORT : rfsa_pkg::CMD_REQUEST;
      if (clock_base < TIME_MAX - 31'd40) begin
        clock_base = clock_base + rfsa_pkg::TIME_W'($urandom_range(0, 6));
      end else begin
        clock_base = TIME_MAX;
      end
      arrival = clock_base;
      // Now and then a job arrives earlier than the one before it.
      if ($urandom_range(0, 11) == 0 && clock_base > 31'd25) begin
        arrival = clock_base - rfsa_pkg::TIME_W'($urandom_range(0, 25));
      end
      if (top_range && $urandom_range(0, 3) == 0) begin
        load = rfsa_pkg::TIME_W'($urandom_range(1, TIME_MAX));
      end else begin
        load = rfsa_pkg::TIME_W'($urandom_range(1, 40));
      end
      offer_item(cmd, arrival, load, 1'b0, '0);
    end
  endtask

  // Receiver: random stalls, runs without stalls and one long hold-off.
  initial begin : result_sink
    int unsigned stall;
    int unsigned run_left;
    int unsigned holds_done;
    result_ready <= 1'b0;
    run_left   = 0;
    holds_done = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_requests != holds_done) begin
        stall = HOLD_CYCLES;
        holds_done++;
      end else if (run_left != 0) begin
        stall = 0;
        run_left--;
      end else if ($urandom_range(0, 15) == 0) begin
        stall = 0;
        run_left = 24;
      end else begin
        stall = $urandom_range(0, 15);
      end
      @(negedge clk_i);
      if (stall != 0) begin
        result_ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      result_ready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid_o) @(posedge clk_i);
    end
  end

  // Result checker: each transfer against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid_o && result_ready) begin
      got = '{accepted: m_axis_tuser_o, index: m_axis_tdata_o[rfsa_pkg::IDX_OUT_W-1:0],
              total: m_axis_tdata_o[rfsa_pkg::IDX_OUT_W +: rfsa_pkg::TOTAL_W],
              last: m_axis_tlast_o};
      if (expected_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result acc=%0d srv=%0d total=%0d last=%0d",
                 $time, got.accepted, got.index, got.total, got.last);
      end else begin
        want = expected_results.pop_front();
        if (got.accepted !== want.accepted || got.index !== want.index ||
            got.total !== want.total || got.last !== want.last) begin
          mismatch_count++;
          $display("%0t: expected acc=%0d srv=%0d total=%0d last=%0d, %s",
                   $time, want.accepted, want.index, want.total, want.last,
                   $sformatf("got acc=%0d srv=%0d total=%0d last=%0d",
                             got.accepted, got.index, got.total, got.last));
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk_i) begin
    if ((item_valid && s_axis_tready_o) || (m_axis_tvalid_o && result_ready) ||
        (cfg_valid && cfg_ready_o) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("rotating_free_server_allocator_core: mismatch");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Main sequence.
  initial begin : stimulus
    plan_row_t row;
    rst_ni     <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    item_valid <= 1'b0;
    item_data  <= '0;
    item_user  <= rfsa_pkg::CMD_REQUEST;
    hold_requests  = 0;
    steady_source  = 1'b0;
    rotate_ptr     = 0;
    server_limit   = rfsa_pkg::CFG_RESET;
    for (int j = 0; j < rfsa_pkg::SERVERS_DEF; j++) begin
      busy_until_q[j] = '0;
      served_q[j]     = '0;
    end

    // Directed plan: reset report, drops, zero and oversize server counts,
    // a start pointer left beyond a shrunk count and an early arrival.
    plan_job(rfsa_pkg::CMD_REPORT,  31'd0,  31'd0, 1'b0, 1'b0, 0, 0);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd0,  31'd1, 1'b1, 1'b1, 0, 1);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd0,  31'd3, 1'b1, 1'b1, 1, 1);
    plan_setup(5'd2);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd0,  31'd4, 1'b1, 1'b0, 0, 0);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd1,  31'd4, 1'b1, 1'b1, 0, 2);
    plan_job(rfsa_pkg::CMD_REPORT,  31'd0,  31'd0, 1'b1, 1'b1, 0, 2);
    plan_setup(5'd0);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd2,  31'd2, 1'b1, 1'b0, 0, 0);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd5,  31'd2, 1'b1, 1'b1, 0, 3);
    plan_setup(5'd31);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd5,  31'd1, 1'b1, 1'b1, 1, 2);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd5,  31'd1, 1'b1, 1'b1, 2, 1);
    plan_job(rfsa_pkg::CMD_REPORT,  31'd0,  31'd0, 1'b1, 1'b1, 0, 3);
    for (int j = 0; j < 4; j++) begin
      plan_job(rfsa_pkg::CMD_REQUEST, 31'd10, 31'd1, 1'b0, 1'b0, 0, 0);
    end
    plan_setup(5'd4);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd20, 31'd1, 1'b0, 1'b0, 0, 0);
    plan_job(rfsa_pkg::CMD_REQUEST, 31'd3,  31'd1, 1'b0, 1'b0, 0, 0);
    plan_job(rfsa_pkg::CMD_REPORT,  31'd0,  31'd0, 1'b0, 1'b0, 0, 0);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_plan[i]) begin
      row = directed_plan[i];
      if (row.kind == ROW_SETUP) begin
        write_server_count(row.setting);
      end else begin
        offer_item(row.cmd, row.arrival, row.load, row.typed, row.want);
      end
    end

    // Random phases over several server counts, ending near the top of time.
    clock_base = 31'd30;
    run_phase(5'd16, 20, 1'b0, 1'b0, 1'b0);
    run_phase(5'd3,  18, 1'b0, 1'b1, 1'b0);
    run_phase(5'd1,  16, 1'b0, 1'b0, 1'b1);
    run_phase(5'd17, 18, 1'b0, 1'b0, 1'b0);
    run_phase(5'd7,  18, 1'b0, 1'b0, 1'b0);
    run_phase(5'd16, 20, 1'b1, 1'b0, 1'b0);
    offer_item(rfsa_pkg::CMD_REQUEST, TIME_MAX, TIME_MAX, 1'b0, '0);
    offer_item(rfsa_pkg::CMD_REPORT, TIME_MAX, TIME_MAX, 1'b0, '0);

    wait_for_drain();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("rotating_free_server_allocator_core: match");
    end else begin
      $display("rotating_free_server_allocator_core: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/rfsa_pkg.sv
rtl/core/rfsa_ram.sv
rtl/core/rotating_free_server_allocator_core.sv
tb/testbench.sv
